[rtl/swm_pkg.sv]
`timescale 1ns / 1ps

package swm_pkg;

  // Window capacity and sample format.
  localparam int WindowMax  = 64;
  localparam int SampleBits = 16;
  localparam int IdxBits    = $clog2(WindowMax);
  localparam int LenBits    = 7;

  localparam logic [LenBits-1:0] LenReset = 7'd3;

  // Register decode uses the word address bit above the byte offset.
  localparam logic RegWindowLen = 1'b0;

  typedef logic signed [SampleBits-1:0] sample_t;

  typedef enum logic [1:0] {
    StIdle,
    StLoad,
    StCmp,
    StSel
  } state_e;

  // Control shared by every cell of the chain.
  typedef struct packed {
    logic               shift;
    logic               load;
    logic               cmp;
    logic [LenBits-1:0] len;
    logic [IdxBits-1:0] target;
  } ctl_t;

endpackage

[rtl/swm_cell.sv]
`timescale 1ns / 1ps

module swm_cell (
  input  logic                        clk_i,
  input  swm_pkg::ctl_t               ctl_i,
  input  logic [swm_pkg::IdxBits-1:0] idx_i,
  input  swm_pkg::sample_t            data_i,
  input  swm_pkg::sample_t            probe_i,
  input  logic [swm_pkg::IdxBits-1:0] probe_idx_i,
  output swm_pkg::sample_t            data_o,
  output swm_pkg::sample_t            probe_o,
  output logic [swm_pkg::IdxBits-1:0] probe_idx_o,
  output logic                        hit_o
);
  import swm_pkg::*;

  sample_t            data_q;
  sample_t            probe_q;
  logic [IdxBits-1:0] pidx_q;
  logic [IdxBits-1:0] rank_q;
  logic [IdxBits-1:0] rank_d;
  logic               probe_in_win;
  logic               probe_lower;

  // A passing sample ranks below this one if it is smaller, or equal and newer.
  assign probe_in_win = {1'b0, pidx_q} < ctl_i.len;
  assign probe_lower  = (probe_q < data_q) || ((probe_q == data_q) && (pidx_q < idx_i));
  assign rank_d       = rank_q + {{(IdxBits-1){1'b0}}, probe_in_win & probe_lower};

  always_ff @(posedge clk_i) begin
    if (ctl_i.shift) begin
      data_q <= data_i;
    end
    if (ctl_i.load) begin
      probe_q <= data_q;
      pidx_q  <= idx_i;
      rank_q  <= '0;
    end else if (ctl_i.cmp) begin
      probe_q <= probe_i;
      pidx_q  <= probe_idx_i;
      rank_q  <= rank_d;
    end
  end

  assign data_o      = data_q;
  assign probe_o     = probe_q;
  assign probe_idx_o = pidx_q;
  assign hit_o       = ({1'b0, idx_i} < ctl_i.len) && (rank_q == ctl_i.target);

endmodule

[rtl/swm_ctrl.sv]
`timescale 1ns / 1ps

module swm_ctrl (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        accept_i,
  input  logic                        out_free_i,
  input  logic [swm_pkg::LenBits-1:0] window_len_i,
  output logic                        ready_o,
  output logic                        out_load_o,
  output swm_pkg::ctl_t               ctl_o
);
  import swm_pkg::*;

  state_e             state_q;
  state_e             state_d;
  logic [IdxBits-1:0] cnt_q;
  logic [IdxBits-1:0] cnt_d;
  logic [LenBits-1:0] fill_q;
  logic [LenBits-1:0] fill_d;
  logic [LenBits-1:0] len_eff;
  logic [LenBits-1:0] len_m1;
  logic               full;

  // A length of zero behaves as one; lengths above capacity saturate.
  always_comb begin
    if (window_len_i == '0) begin
      len_eff = LenBits'(1);
    end else if (window_len_i > LenBits'(WindowMax)) begin
      len_eff = LenBits'(WindowMax);
    end else begin
      len_eff = window_len_i;
    end
  end

  assign len_m1 = len_eff - LenBits'(1);
  assign full   = fill_q >= len_eff;

  always_comb begin
    state_d = state_q;
    case (state_q)
      StIdle: begin
        if (accept_i) state_d = StLoad;
      end
      StLoad: begin
        state_d = full ? StCmp : StIdle;
      end
      StCmp: begin
        if (cnt_q == '1) state_d = StSel;
      end
      StSel: begin
        if (out_free_i) state_d = StIdle;
      end
      default: state_d = StIdle;
    endcase
  end

  always_comb begin
    ready_o      = 1'b0;
    out_load_o   = 1'b0;
    ctl_o        = '0;
    ctl_o.shift  = accept_i;
    ctl_o.len    = len_eff;
    ctl_o.target = len_m1[IdxBits:1];
    case (state_q)
      StIdle:  ready_o    = 1'b1;
      StLoad:  ctl_o.load = 1'b1;
      StCmp:   ctl_o.cmp  = 1'b1;
      StSel:   out_load_o = out_free_i;
      default: ready_o    = 1'b0;
    endcase
  end

  assign cnt_d  = (state_q == StCmp) ? cnt_q + IdxBits'(1) : '0;
  assign fill_d = (accept_i && (fill_q < LenBits'(WindowMax))) ? fill_q + LenBits'(1) : fill_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      cnt_q   <= '0;
      fill_q  <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      fill_q  <= fill_d;
    end
  end

`ifndef SYNTHESIS
  a_sel_needs_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StSel) |-> full)
    else $error("median selected from a window that is not full");

  a_cmp_full_sweep: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == StCmp) && (cnt_q != '1)) |=> (state_q == StCmp))
    else $error("rank sweep ended before every sample passed each cell");
`endif

endmodule

[rtl/sliding_window_median.sv]
`timescale 1ns / 1ps

// Sliding-window median filter.
// Samples enter on the sample channel (sample_i, sample_valid_i, sample_ready_o);
// each transfer pushes the sample into a chain of 64 cells that holds the newest
// samples in arrival order. Once at least window_len samples are held, the lower
// median of the newest window_len samples is delivered on the median channel
// (median_o, median_valid_o, median_ready_i); before that a sample yields nothing.
// window_len is written through the APB port at byte address 0; zero acts as one
// and values above 64 act as 64. Write it only while the filter is idle.
// After a sample transfer the chain is copied into the rotating probe line; then
// every sample travels past every cell while each cell counts its rank; then the
// cell of the wanted rank is picked into the output register. The filter takes
// no new sample until that pick is done once the window is full, and while it is
// still filling it takes no new sample until the chain has been copied.
// If the receiver stalls, the median waits in the output register; the filter
// still takes the next sample, and only stalls its input again once a second
// median is ready while the first is still waiting.
// Reset clears the fill count, the state and the output valid, and sets
// window_len to 3; held sample values are not cleared.

module sliding_window_median (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic signed [swm_pkg::SampleBits-1:0] sample_i,
  input  logic                               sample_valid_i,
  output logic                               sample_ready_o,
  output logic signed [swm_pkg::SampleBits-1:0] median_o,
  output logic                               median_valid_o,
  input  logic                               median_ready_i,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [2:0]                         paddr,
  input  logic [31:0]                        pwdata,
  output logic [31:0]                        prdata,
  output logic                               pready
);
  import swm_pkg::*;

  ctl_t               ctl;
  logic               accept;
  logic               out_free;
  logic               out_load;
  logic [LenBits-1:0] window_len_q;
  sample_t            data   [WindowMax];
  sample_t            probe  [WindowMax];
  logic [IdxBits-1:0] pidx   [WindowMax];
  logic [WindowMax-1:0] hit;
  sample_t            sel;
  sample_t            median_q;
  logic               median_valid_q;

  // The configuration port never waits. Only the word address bit decodes.
  assign pready = 1'b1;
  assign prdata = (paddr[2] == RegWindowLen) ? {{(32-LenBits){1'b0}}, window_len_q} : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      window_len_q <= LenReset;
    end else if (psel && penable && pwrite && pready && (paddr[2] == RegWindowLen)) begin
      window_len_q <= pwdata[LenBits-1:0];
    end
  end

  assign accept   = sample_valid_i && sample_ready_o;
  assign out_free = !median_valid_q || median_ready_i;

  swm_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .accept_i     (accept),
    .out_free_i   (out_free),
    .window_len_i (window_len_q),
    .ready_o      (sample_ready_o),
    .out_load_o   (out_load),
    .ctl_o        (ctl)
  );

  // Cell g holds the sample of age g. The data line shifts toward higher ages on
  // each transfer; the probe line rotates toward lower indexes during the sweep,
  // so every cell sees every held sample exactly once.
  for (genvar g = 0; g < WindowMax; g++) begin : g_cell
    swm_cell u_cell (
      .clk_i       (clk_i),
      .ctl_i       (ctl),
      .idx_i       (IdxBits'(g)),
      .data_i      ((g == 0) ? sample_i : data[(g + WindowMax - 1) % WindowMax]),
      .probe_i     (probe[(g + 1) % WindowMax]),
      .probe_idx_i (pidx[(g + 1) % WindowMax]),
      .data_o      (data[g]),
      .probe_o     (probe[g]),
      .probe_idx_o (pidx[g]),
      .hit_o       (hit[g])
    );
  end

  // Exactly one cell inside the window holds the wanted rank.
  always_comb begin
    sel = '0;
    for (int i = 0; i < WindowMax; i++) begin
      sel = sel | (data[i] & {SampleBits{hit[i]}});
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      median_q <= sel;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      median_valid_q <= 1'b0;
    end else if (out_load) begin
      median_valid_q <= 1'b1;
    end else if (median_ready_i) begin
      median_valid_q <= 1'b0;
    end
  end

  assign median_o       = median_q;
  assign median_valid_o = median_valid_q;

`ifndef SYNTHESIS
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> !sample_ready_o)
    else $error("second sample taken while one is still being ranked");

  a_single_hit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |-> $onehot(hit))
    else $error("rank match is not unique in the window");
`endif

endmodule

[tb/sv/sliding_window_median_tb.sv]
`timescale 1ns / 1ps

module sliding_window_median_tb;
  import swm_pkg::*;

  // Run control. About 420 samples with a slow receiver stay well below the
  // cycle limit.
  localparam int unsigned CycleLimit  = 400000;
  localparam int unsigned SettleCycles = 80;   // lets any sample still being ranked finish
  localparam int unsigned LongHold     = 600;  // receiver back-pressure stretch
  localparam int unsigned RandSegItems = 22;

  typedef enum logic {
    RowSample,
    RowLen
  } row_kind_e;

  // One row of the directed table: either a sample transfer or a write of
  // window_len. Where typed is set, want is the median known by inspection.
  typedef struct packed {
    row_kind_e          kind;
    sample_t            smp;
    logic               typed;
    sample_t            want;
    logic [LenBits-1:0] len;
  } dir_row_t;

  localparam int DirRows = 25;

  logic                 clk_i          = 1'b0;
  logic                 rst_ni         = 1'b0;
  sample_t              sample_i       = '0;
  logic                 sample_valid_i = 1'b0;
  logic                 sample_ready_o;
  sample_t              median_o;
  logic                 median_valid_o;
  logic                 median_ready_i = 1'b0;
  logic                 psel           = 1'b0;
  logic                 penable        = 1'b0;
  logic                 pwrite         = 1'b0;
  logic [2:0]           paddr          = '0;
  logic [31:0]          pwdata         = '0;
  logic [31:0]          prdata;
  logic                 pready;

  // Shadow of the filter state, kept up to date by the monitor and APB writes.
  sample_t              recent_samples [WindowMax];
  logic [IdxBits-1:0]   recent_wr   = '0;
  int unsigned          recent_fill = 0;
  logic [LenBits-1:0]   len_shadow  = LenReset;

  sample_t              pending_medians [$];
  int unsigned          mismatch_cnt = 0;

  // Idle percentages for both sides and the long receiver hold request.
  int unsigned          send_idle_pct = 0;
  int unsigned          recv_idle_pct = 0;
  bit                   hold_req      = 1'b0;
  int unsigned          hold_left     = 0;

  // Median known by inspection for the sample currently being offered.
  bit                   typed_on  = 1'b0;
  sample_t              typed_val = '0;

  // The directed table. It starts from the reset length of three, then covers
  // a length of zero (acts as one, so the median is the sample itself) with the
  // field extremes and alternating bit patterns, a length of two (lower median
  // is the minimum), a length of four with repeated values, lengths above the
  // capacity (both act as 64, and the window is not full yet so nothing comes
  // out), and finally a drop to six mid-stream, which emits at once because
  // enough samples are already held.
  dir_row_t dir_rows [DirRows] = '{
    '{RowSample, 16'sd5,      1'b0, 16'sd0,      7'd0},
    '{RowSample, -16'sd7,     1'b0, 16'sd0,      7'd0},
    '{RowSample, 16'sd100,    1'b1, 16'sd5,      7'd0},
    '{RowLen,    16'sd0,      1'b0, 16'sd0,      7'd0},
    '{RowSample, 16'h8000,    1'b1, 16'h8000,    7'd0},
    '{RowSample, 16'h7FFF,    1'b1, 16'h7FFF,    7'd0},
    '{RowSample, 16'h0000,    1'b1, 16'h0000,    7'd0},
    '{RowSample, 16'hFFFF,    1'b1, 16'hFFFF,    7'd0},
    '{RowSample, 16'h5555,    1'b1, 16'h5555,    7'd0},
    '{RowSample, 16'hAAAA,    1'b1, 16'hAAAA,    7'd0},
    '{RowLen,    16'sd0,      1'b0, 16'sd0,      7'd2},
    '{RowSample, 16'h7FFF,    1'b0, 16'sd0,      7'd0},
    '{RowSample, 16'h8000,    1'b1, 16'h8000,    7'd0},
    '{RowLen,    16'sd0,      1'b0, 16'sd0,      7'd4},
    '{RowSample, 16'sd3,      1'b0, 16'sd0,      7'd0},
    '{RowSample, 16'sd3,      1'b0, 16'sd0,      7'd0},
    '{RowSample, -16'sd3,     1'b0, 16'sd0,      7'd0},
    '{RowSample, 16'sd3,      1'b0, 16'sd0,      7'd0},
    '{RowLen,    16'sd0,      1'b0, 16'sd0,      7'd127},
    '{RowSample, 16'sd1,      1'b0, 16'sd0,      7'd0},
    '{RowSample, 16'sd2,      1'b0, 16'sd0,      7'd0},
    '{RowLen,    16'sd0,      1'b0, 16'sd0,      7'd65},
    '{RowSample, 16'sd4,      1'b0, 16'sd0,      7'd0},
    '{RowLen,    16'sd0,      1'b0, 16'sd0,      7'd6},
    '{RowSample, 16'sd10,     1'b0, 16'sd0,      7'd0}
  };

  sliding_window_median dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .sample_i       (sample_i),
    .sample_valid_i (sample_valid_i),
    .sample_ready_o (sample_ready_o),
    .median_o       (median_o),
    .median_valid_o (median_valid_o),
    .median_ready_i (median_ready_i),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready)
  );

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  // Pushes one sample into the shadow ring and works out the lower median of
  // the newest window, if the window is full. The ring index wraps at the
  // capacity, and a length of zero or above the capacity is clamped.
  function automatic bit predict_median(input sample_t s, output sample_t med);
    sample_t     win [WindowMax];
    sample_t     v;
    int unsigned n;
    int unsigned need;
    int unsigned i;
    int unsigned j;
    recent_samples[recent_wr] = s;
    recent_wr = recent_wr + 1'b1;
    if (recent_fill < WindowMax) recent_fill++;
    n = 32'(len_shadow);
    if (n == 0) n = 1;
    if (n > WindowMax) n = WindowMax;
    med = '0;
    if (recent_fill < n) return 1'b0;
    for (j = 0; j < n; j++) begin
      win[j] = recent_samples[recent_wr - IdxBits'(j + 1)];
    end
    // Insertion sort, ascending, on signed values; duplicates stay separate.
    for (i = 1; i < n; i++) begin
      v = win[i];
      j = i;
      while (j > 0 && win[j-1] > v) begin
        win[j] = win[j-1];
        j--;
      end
      win[j] = v;
    end
    need = (n + 1) / 2;
    med = win[need-1];
    return 1'b1;
  endfunction

  task automatic report_mismatch(input string what, input sample_t got, input sample_t want);
    mismatch_cnt++;
    $display("%s: got %0d, expected %0d at %0t", what, got, want, $time);
  endtask

  // Transfer monitor. Both channels are looked at on the rising edge, before
  // the design's own updates land, so the values seen are the ones that were
  // transferred. A sample transfer feeds the predictor; a median transfer is
  // compared with the oldest expectation.
  always @(posedge clk_i) begin
    sample_t med;
    sample_t want;
    if (rst_ni) begin
      if (sample_valid_i && sample_ready_o) begin
        if (predict_median(sample_i, med)) begin
          want = typed_on ? typed_val : med;
          pending_medians = {pending_medians, want};
        end
      end
      if (median_valid_o && median_ready_i) begin
        if (pending_medians.size() == 0) begin
          report_mismatch("median with no sample pending", median_o, '0);
        end else begin
          want = pending_medians.pop_front();
          if (median_o !== want) report_mismatch("median value", median_o, want);
        end
      end
    end
  end

  // Receiver. Ready changes on the falling edge; a hold request keeps it low
  // for a long stretch so that the filter fills up and stalls its input.
  always @(negedge clk_i) begin
    if (hold_req) begin
      hold_left = LongHold;
      hold_req  = 1'b0;
    end
    if (hold_left != 0) begin
      hold_left--;
      median_ready_i <= 1'b0;
    end else begin
      median_ready_i <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Offers one sample; called and returning on a falling edge. Valid is only
  // lowered when the sender decides to idle, so back-to-back transfers keep it
  // high without a glitch.
  task automatic offer_sample(input sample_t s, input bit typed, input sample_t want);
    if ($urandom_range(99) < send_idle_pct) begin
      sample_valid_i <= 1'b0;
      do @(negedge clk_i); while ($urandom_range(99) < send_idle_pct);
    end
    typed_on  = typed;
    typed_val = want;
    sample_i       <= s;
    sample_valid_i <= 1'b1;
    do @(posedge clk_i); while (!sample_ready_o);
    @(negedge clk_i);
  endtask

  // Stops offering, waits for every expected median, then lets the filter
  // finish any sample that yields no median before anything else happens.
  task automatic drain_filter();
    sample_valid_i <= 1'b0;
    while (pending_medians.size() != 0) @(negedge clk_i);
    repeat (SettleCycles) @(negedge clk_i);
  endtask

  // APB write of window_len: setup cycle, then access cycle. The upper data
  // bits carry random junk, since only the low seven bits are kept.
  task automatic write_window_len(input logic [LenBits-1:0] v);
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    penable <= 1'b0;
    paddr   <= {RegWindowLen, 2'b00};
    pwdata  <= ($urandom & 32'hFFFF_FF80) | 32'(v);
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    len_shadow = v;
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // Random samples: full range for bit coverage, a narrow band around zero
  // for many ties, the two extremes, and a band that wraps across them.
  function automatic sample_t random_sample();
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 45) return sample_t'($urandom);
    if (pick < 80) return sample_t'(int'($urandom_range(6)) - 3);
    if (pick < 90) return pick[0] ? 16'h7FFF : 16'h8000;
    return sample_t'(32'h7FFC + $urandom_range(7));
  endfunction

  initial begin
    repeat (CycleLimit) @(posedge clk_i);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin
    int                 ph;
    int                 seg;
    logic [LenBits-1:0] len_pick;

    // First idling mode covers the directed table too.
    send_idle_pct = 28;
    recv_idle_pct = 73;

    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    for (int r = 0; r < DirRows; r++) begin
      if (dir_rows[r].kind == RowLen) begin
        drain_filter();
        write_window_len(dir_rows[r].len);
      end else begin
        offer_sample(dir_rows[r].smp, dir_rows[r].typed, dir_rows[r].want);
      end
    end

    // Random part in three idling modes. Each mode walks through several
    // window lengths, the extremes among them, with a drain before each write.
    for (ph = 0; ph < 3; ph++) begin
      case (ph)
        0: begin
          send_idle_pct = 28;
          recv_idle_pct = 73;
        end
        1: begin
          send_idle_pct = 73;
          recv_idle_pct = 28;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      for (seg = 0; seg < 6; seg++) begin
        case (seg)
          0: len_pick = LenBits'($urandom_range(64, 1));
          1: len_pick = 7'd64;
          2: len_pick = 7'd1;
          3: len_pick = 7'd0;
          4: len_pick = LenBits'($urandom_range(127, 65));
          default: len_pick = LenBits'($urandom_range(9, 2));
        endcase
        drain_filter();
        write_window_len(len_pick);
        // With no idling at all, the receiver holds off once while the sender
        // keeps offering, so the filter's input stalls.
        if (ph == 2 && seg == 1) hold_req = 1'b1;
        repeat (RandSegItems) offer_sample(random_sample(), 1'b0, '0);
      end
    end

    drain_filter();
    if (mismatch_cnt == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

[sliding_window_median.f]
rtl/swm_pkg.sv
rtl/swm_cell.sv
rtl/swm_ctrl.sv
rtl/sliding_window_median.sv
tb/sv/sliding_window_median_tb.sv
